// ===== hdl/pcfr_pkg.sv =====
package pcfr_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned GeneW  = 8;
  localparam int unsigned FitW   = 9;
  localparam int unsigned IdxW   = 6;

  // Fitness saturates at this count of set bits.
  localparam logic [FitW-1:0] FitMax = 9'd256;

  // Default store capacity, in individuals.
  localparam int unsigned PopMaxDefault = 64;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // One finished individual, as handed from the front to the back.
  typedef struct packed {
    logic            end_pop;
    logic [FitW-1:0] fit;
  } ind_rec_t;

  // Back state: inserting finished individuals, or streaming out the ranking.
  typedef enum logic {
    BK_FILL,
    BK_DRAIN
  } back_state_e;

endpackage

// ===== hdl/popcount_fitness_rank_sorter_top.sv =====
// Takes one chromosome byte per cycle while the queue has room; an individual
// is ranked in the insertion cell row after its last byte enters the
// two-entry queue. After the population's last byte, results stream out one
// per cycle from the head cell while out_stall_i is low; bytes of the next
// population queue up and stall once the queue fills.
// Reset is asynchronous, active low, and leaves the store empty with no
// clearing pass.
module popcount_fitness_rank_sorter_top #(
  parameter int unsigned POP_MAX = pcfr_pkg::PopMaxDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pcfr_pkg::GeneW-1:0] gene_byte_i,
  input  logic                       end_of_individual_i,
  input  logic                       end_of_population_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pcfr_pkg::IdxW-1:0]  individual_index_o,
  output logic [pcfr_pkg::FitW-1:0]  fitness_o,
  output logic                       last_result_o
);

  logic               q_push, q_full, q_pop, q_avail;
  pcfr_pkg::ind_rec_t rec_in, rec_out;

  // Front: bit counting per individual.
  pcfr_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .gene_byte_i         (gene_byte_i),
    .end_of_individual_i (end_of_individual_i),
    .end_of_population_i (end_of_population_i),
    .q_full_i            (q_full),
    .q_push_o            (q_push),
    .q_rec_o             (rec_in)
  );

  // Short queue between counting and ranking.
  pcfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .rec_o   (rec_out)
  );

  // Back: sorted insertion and result streaming.
  pcfr_back #(
    .PopMax (POP_MAX)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_avail_i          (q_avail),
    .q_rec_i            (rec_out),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .individual_index_o (individual_index_o),
    .fitness_o          (fitness_o),
    .last_result_o      (last_result_o)
  );

`ifndef SYNTH
  // After the final result is taken the store is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_result_o |=> !out_valid_o)
    else $error("result shown after the last one of a ranking");

  // Successive results come in rank order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=> out_valid_o &&
      ((fitness_o < $past(fitness_o)) ||
       ((fitness_o == $past(fitness_o)) &&
        (individual_index_o > $past(individual_index_o)))))
    else $error("results out of rank order");

  // Reported fitness never passes the saturation value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fitness_o <= pcfr_pkg::FitMax)
    else $error("fitness above saturation");
`endif

endmodule

// ===== hdl/pcfr_front.sv =====
module pcfr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pcfr_pkg::GeneW-1:0]  gene_byte_i,
  input  logic                        end_of_individual_i,
  input  logic                        end_of_population_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output pcfr_pkg::ind_rec_t          q_rec_o
);

  logic [pcfr_pkg::FitW-1:0] acc_q, acc_d;
  logic [3:0]                ones;
  logic [pcfr_pkg::FitW:0]   sum;
  logic [pcfr_pkg::FitW-1:0] sat;
  logic                      accept;
  logic                      ends;

  // A request is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign ends       = end_of_individual_i || end_of_population_i;

  // Count the set bits of the incoming byte.
  always_comb begin
    ones = '0;
    for (int i = 0; i < pcfr_pkg::GeneW; i++) begin
      ones = ones + 4'(gene_byte_i[i]);
    end
  end

  // Add to the running count and saturate.
  always_comb begin
    sum = {1'b0, acc_q} + (pcfr_pkg::FitW+1)'(ones);
    if (sum > {1'b0, pcfr_pkg::FitMax}) begin
      sat = pcfr_pkg::FitMax;
    end else begin
      sat = sum[pcfr_pkg::FitW-1:0];
    end
  end

  // The last byte of an individual hands its fitness to the queue.
  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = ends ? '0 : sat;
    end
  end

  assign q_push_o        = accept && ends;
  assign q_rec_o.fit     = sat;
  assign q_rec_o.end_pop = end_of_population_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== hdl/pcfr_queue.sv =====
module pcfr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pcfr_pkg::ind_rec_t  rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                avail_o,
  output pcfr_pkg::ind_rec_t  rec_o
);

  localparam int unsigned PtrW = $clog2(pcfr_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(pcfr_pkg::QueueDepth + 1);

  pcfr_pkg::ind_rec_t slot_q [pcfr_pkg::QueueDepth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]    cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(pcfr_pkg::QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign rec_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  // Storage for queued individuals.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= rec_i;
    end
  end

  // Pointers wrap around the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(pcfr_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(pcfr_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pcfr_back.sv =====
module pcfr_back #(
  parameter int unsigned PopMax = pcfr_pkg::PopMaxDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_avail_i,
  input  pcfr_pkg::ind_rec_t         q_rec_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pcfr_pkg::IdxW-1:0]  individual_index_o,
  output logic [pcfr_pkg::FitW-1:0]  fitness_o,
  output logic                       last_result_o
);

  localparam int unsigned CntW = $clog2(PopMax + 1);

  pcfr_pkg::back_state_e     state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [pcfr_pkg::IdxW-1:0] idx_q [PopMax];
  logic [pcfr_pkg::FitW-1:0] fit_q [PopMax];
  logic [PopMax-1:0]         keep;
  logic                      do_insert;
  logic                      do_shift;
  logic                      out_take;

  // Entries below the fill count are live; the live ones stay sorted, so the
  // cells that outrank the newcomer always form a prefix.
  always_comb begin
    for (int i = 0; i < PopMax; i++) begin
      keep[i] = (CntW'(i) < count_q) && (fit_q[i] >= q_rec_i.fit);
    end
  end

  assign out_valid_o        = (state_q == pcfr_pkg::BK_DRAIN) && (count_q != '0);
  assign out_take           = out_valid_o && !out_stall_i;
  assign individual_index_o = idx_q[0];
  assign fitness_o          = fit_q[0];
  assign last_result_o      = (count_q == CntW'(1));

  // Sequencer: insert queued individuals (dropping those past PopMax) until one
  // closes the population, then stream the ranking out of the head cell.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    q_pop_o   = 1'b0;
    do_insert = 1'b0;
    do_shift  = 1'b0;
    case (state_q)
      pcfr_pkg::BK_FILL: begin
        if (q_avail_i) begin
          q_pop_o = 1'b1;
          if (count_q != CntW'(PopMax)) begin
            do_insert = 1'b1;
            count_d   = count_q + 1'b1;
          end
          if (q_rec_i.end_pop) begin
            state_d = pcfr_pkg::BK_DRAIN;
          end
        end
      end
      pcfr_pkg::BK_DRAIN: begin
        if (out_take) begin
          do_shift = 1'b1;
          count_d  = count_q - 1'b1;
          if (last_result_o) begin
            state_d = pcfr_pkg::BK_FILL;
          end
        end
      end
      default: begin
        state_d = pcfr_pkg::BK_FILL;
      end
    endcase
  end

  // Row of sort cells: each one holds, takes the newcomer, or takes its
  // upper neighbor on insert, and takes its lower neighbor while draining.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PopMax; i++) begin
      if (do_insert) begin
        if (!keep[i]) begin
          if (i == 0) begin
            idx_q[i] <= pcfr_pkg::IdxW'(count_q);
            fit_q[i] <= q_rec_i.fit;
          end else if (keep[i-1]) begin
            idx_q[i] <= pcfr_pkg::IdxW'(count_q);
            fit_q[i] <= q_rec_i.fit;
          end else begin
            idx_q[i] <= idx_q[i-1];
            fit_q[i] <= fit_q[i-1];
          end
        end
      end else if (do_shift && (i < PopMax - 1)) begin
        idx_q[i] <= idx_q[i+1];
        fit_q[i] <= fit_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcfr_pkg::BK_FILL;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

endmodule
